// ----- src/pfdm_pkg.sv -----
package pfdm_pkg;

  localparam int TICK_HZ_W  = 27;
  localparam int PERIOD_W   = 32;
  localparam int DUTY_W     = 4;
  localparam int PULSES_W   = 16;
  localparam int WTICK_W    = 8;
  localparam int OVF_W      = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int OP_W       = 2;
  localparam int FRAC_W     = 16;
  localparam int FREQ_W     = 32;
  localparam int DUTY_SCALE = 10;

  localparam logic [OP_W-1:0] OP_OVERFLOW = 2'd0;
  localparam logic [OP_W-1:0] OP_RISE     = 2'd1;
  localparam logic [OP_W-1:0] OP_FALL     = 2'd2;
  localparam logic [OP_W-1:0] OP_TICK     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_TICK_HZ      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MAX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_MIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSES   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WTICKS   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OVF_LIMIT    = 3'd7;

  localparam logic [TICK_HZ_W-1:0] RST_TICK_HZ    = 27'd48000000;
  localparam logic [PERIOD_W-1:0]  RST_PERIOD_MIN = 32'd10666;
  localparam logic [PERIOD_W-1:0]  RST_PERIOD_MAX = 32'd4800000;
  localparam logic [DUTY_W-1:0]    RST_DUTY_MIN   = 4'd1;
  localparam logic [DUTY_W-1:0]    RST_DUTY_MAX   = 4'd9;
  localparam logic [PULSES_W-1:0]  RST_MIN_PULSES = 16'd10;
  localparam logic [WTICK_W-1:0]   RST_MAX_WTICKS = 8'd10;
  localparam logic [OVF_W-1:0]     RST_OVF_LIMIT  = 14'd10000;

  typedef struct packed {
    logic [TICK_HZ_W-1:0] tick_hz;
    logic [PERIOD_W-1:0]  period_min;
    logic [PERIOD_W-1:0]  period_max;
    logic [DUTY_W-1:0]    duty_min;
    logic [DUTY_W-1:0]    duty_max;
    logic [PULSES_W-1:0]  min_pulses;
    logic [WTICK_W-1:0]   max_window_ticks;
    logic [OVF_W-1:0]     overflow_limit;
  } cfg_t;

  typedef struct packed {
    logic take;
    logic mul;
    logic div_init;
    logic div_step;
    logic div_last;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic closed;
  } sts_t;

endpackage

// ----- src/pfdm_ctrl.sv -----
module pfdm_ctrl import pfdm_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_op,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  sts_t            sts,
  output cmd_t            cmd
);

  localparam int STEP_W = $clog2(FREQ_W);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_CHK  = 5'b00100,
    S_DIV  = 5'b01000,
    S_PUT  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              take;

  assign in_ready  = (state_r == S_IDLE);
  assign take      = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.take      = take;
    unique case (state_r)
      S_IDLE: begin
        if (take && in_op == OP_TICK) begin
          state_nxt = sts.closed ? S_MUL : S_PUT;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.div_init = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_W'(FREQ_W - 1)) begin
          cmd.div_last = 1'b1;
          state_nxt    = S_PUT;
        end
      end
      S_PUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- src/pfdm_datapath.sv -----
module pfdm_datapath import pfdm_pkg::*; #(
  parameter int CAPTURE_WIDTH = 16,
  parameter int SUM_WIDTH     = 40,
  parameter int COUNT_WIDTH   = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  logic [OP_W-1:0]          in_op,
  input  logic [CAPTURE_WIDTH-1:0] in_capture_value,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  output logic [SUM_WIDTH-1:0]     out_window_sum,
  output logic [COUNT_WIDTH-1:0]   out_window_count,
  output logic [FREQ_W-1:0]        out_freq_q16,
  output logic                     out_window_closed
);

  localparam int RPW  = OVF_W + CAPTURE_WIDTH + 1;
  localparam int PWW  = (RPW > PERIOD_W) ? RPW : PERIOD_W;
  localparam int DW   = (RPW + DUTY_W > PERIOD_W + DUTY_W) ? RPW + DUTY_W : PERIOD_W + DUTY_W;
  localparam int CPW  = (COUNT_WIDTH > PULSES_W) ? COUNT_WIDTH : PULSES_W;
  localparam int AW   = TICK_HZ_W + COUNT_WIDTH;
  localparam int SHW  = SUM_WIDTH + FRAC_W;
  localparam int CMPW = (AW > SHW) ? AW : SHW;

  // measurement state
  logic [CAPTURE_WIDTH-1:0] last_rise_r;
  logic [OVF_W-1:0]         rise_ovf_r, fall_ovf_r;
  logic [PERIOD_W-1:0]      held_period_r;
  logic [COUNT_WIDTH-1:0]   count_r;
  logic [SUM_WIDTH-1:0]     sum_r;
  logic [WTICK_W-1:0]       ticks_r;
  logic [FREQ_W-1:0]        held_freq_r;

  // window close and divider
  logic [COUNT_WIDTH-1:0]   cnt_snap_r;
  logic [SUM_WIDTH-1:0]     sum_snap_r;
  logic                     closed_snap_r;
  logic [AW-1:0]            a_r;
  logic [SUM_WIDTH-1:0]     rem_r;
  logic [FREQ_W-1:0]        lo_r, q_r;
  logic                     sat_r, zero_r;

  logic [SUM_WIDTH-1:0]     out_sum_r;
  logic [COUNT_WIDTH-1:0]   out_count_r;
  logic [FREQ_W-1:0]        out_freq_r;
  logic                     out_closed_r;

  logic [CAPTURE_WIDTH-1:0] diff;
  logic [RPW-1:0]           rise_span, fall_span;
  logic [PWW-1:0]           rise_w;
  logic [PERIOD_W-1:0]      period_new;
  logic [DW-1:0]            p10, lo_bound, hi_bound;
  logic                     pass;
  logic [COUNT_WIDTH-1:0]   count_inc;
  logic [SUM_WIDTH:0]       sum_add;
  logic [SUM_WIDTH-1:0]     sum_new;
  logic [WTICK_W-1:0]       ticks_inc;
  logic                     closed;
  logic [SUM_WIDTH:0]       trial;
  logic                     ge;
  logic [SUM_WIDTH-1:0]     rem_step;
  logic [FREQ_W-1:0]        q_step, freq_new;

  assign diff       = in_capture_value - last_rise_r;
  assign rise_span  = RPW'({rise_ovf_r, {CAPTURE_WIDTH{1'b0}}}) + RPW'(diff);
  assign fall_span  = RPW'({fall_ovf_r, {CAPTURE_WIDTH{1'b0}}}) + RPW'(diff);
  assign rise_w     = PWW'(rise_span);
  assign period_new = (rise_w > PWW'({PERIOD_W{1'b1}})) ? '1 : PERIOD_W'(rise_w);

  assign p10      = DW'(fall_span) * DW'(DUTY_SCALE);
  assign lo_bound = DW'(held_period_r) * DW'(cfg.duty_min);
  assign hi_bound = DW'(held_period_r) * DW'(cfg.duty_max);
  assign pass     = (held_period_r != '0) && (held_period_r >= cfg.period_min) &&
                    (held_period_r <= cfg.period_max) && (p10 >= lo_bound) &&
                    (p10 <= hi_bound);

  assign count_inc = (&count_r) ? count_r : count_r + 1'b1;
  assign sum_add   = (SUM_WIDTH + 1)'(sum_r) + (SUM_WIDTH + 1)'(held_period_r);
  assign sum_new   = sum_add[SUM_WIDTH] ? '1 : sum_add[SUM_WIDTH-1:0];
  assign ticks_inc = (&ticks_r) ? ticks_r : ticks_r + 1'b1;
  assign closed    = (CPW'(count_r) >= CPW'(cfg.min_pulses)) ||
                     (ticks_inc >= cfg.max_window_ticks);

  assign sts.closed = closed;

  // restoring division, one quotient bit per step
  assign trial    = {rem_r, lo_r[FREQ_W-1]};
  assign ge       = trial >= {1'b0, sum_snap_r};
  assign rem_step = ge ? SUM_WIDTH'(trial - {1'b0, sum_snap_r}) : SUM_WIDTH'(trial);
  assign q_step   = {q_r[FREQ_W-2:0], ge};
  assign freq_new = zero_r ? '0 : (sat_r ? '1 : q_step);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_rise_r   <= '0;
      rise_ovf_r    <= '0;
      fall_ovf_r    <= '0;
      held_period_r <= '0;
      count_r       <= '0;
      sum_r         <= '0;
      ticks_r       <= '0;
      held_freq_r   <= '0;
    end else begin
      if (cmd.take) begin
        unique case (in_op)
          OP_OVERFLOW: begin
            if (rise_ovf_r < cfg.overflow_limit) begin
              rise_ovf_r <= rise_ovf_r + 1'b1;
            end
            if (fall_ovf_r < cfg.overflow_limit) begin
              fall_ovf_r <= fall_ovf_r + 1'b1;
            end
          end
          OP_RISE: begin
            held_period_r <= period_new;
            rise_ovf_r    <= '0;
            fall_ovf_r    <= '0;
            last_rise_r   <= in_capture_value;
          end
          OP_FALL: begin
            if (pass) begin
              count_r <= count_inc;
              sum_r   <= sum_new;
            end
          end
          OP_TICK: begin
            if (closed) begin
              count_r <= '0;
              sum_r   <= '0;
              ticks_r <= '0;
            end else begin
              ticks_r <= ticks_inc;
            end
          end
          default: ;
        endcase
      end
      if (cmd.div_last) begin
        held_freq_r <= freq_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && in_op == OP_TICK) begin
      cnt_snap_r    <= count_r;
      sum_snap_r    <= sum_r;
      closed_snap_r <= closed;
    end
    if (cmd.mul) begin
      a_r <= AW'(cfg.tick_hz) * AW'(cnt_snap_r);
    end
    if (cmd.div_init) begin
      sat_r  <= CMPW'(a_r) >= CMPW'({sum_snap_r, {FRAC_W{1'b0}}});
      zero_r <= (sum_snap_r == '0);
      rem_r  <= SUM_WIDTH'(a_r >> FRAC_W);
      lo_r   <= {a_r[FRAC_W-1:0], {(FREQ_W - FRAC_W){1'b0}}};
      q_r    <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= rem_step;
      lo_r  <= lo_r << 1;
      q_r   <= q_step;
    end
    if (cmd.out_load) begin
      out_sum_r    <= sum_snap_r;
      out_count_r  <= cnt_snap_r;
      out_freq_r   <= held_freq_r;
      out_closed_r <= closed_snap_r;
    end
  end

  assign out_window_sum    = out_sum_r;
  assign out_window_count  = out_count_r;
  assign out_freq_q16      = out_freq_r;
  assign out_window_closed = out_closed_r;

endmodule

// ----- src/pulse_frequency_duty_meter_core.sv -----
// overflow, rising and falling capture transactions: taken while the controller stays idle, in_ready stays high
// window tick that leaves the window open: S_PUT registers the result once the output register is free
// window tick that closes the window: the result passes through the tick_hz x count multiply,
//   the range check and the 32-step restoring divider before S_PUT registers it
// in_ready is low while a tick is in flight and returns once its result sits in the output register
// synchronous active-low reset clears all measurement state and loads the register defaults
module pulse_frequency_duty_meter_core import pfdm_pkg::*; #(
  parameter int CAPTURE_WIDTH = 16,
  parameter int SUM_WIDTH     = 40,
  parameter int COUNT_WIDTH   = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          in_op,
  input  logic [CAPTURE_WIDTH-1:0] in_capture_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [SUM_WIDTH-1:0]     out_window_sum,
  output logic [COUNT_WIDTH-1:0]   out_window_count,
  output logic [FREQ_W-1:0]        out_freq_q16,
  output logic                     out_window_closed,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int CPW = (COUNT_WIDTH > PULSES_W) ? COUNT_WIDTH : PULSES_W;

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_hz          <= RST_TICK_HZ;
      cfg_r.period_min       <= RST_PERIOD_MIN;
      cfg_r.period_max       <= RST_PERIOD_MAX;
      cfg_r.duty_min         <= RST_DUTY_MIN;
      cfg_r.duty_max         <= RST_DUTY_MAX;
      cfg_r.min_pulses       <= RST_MIN_PULSES;
      cfg_r.max_window_ticks <= RST_MAX_WTICKS;
      cfg_r.overflow_limit   <= RST_OVF_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TICK_HZ:    cfg_r.tick_hz          <= cfg_wdata[TICK_HZ_W-1:0];
        REG_PERIOD_MIN: cfg_r.period_min       <= cfg_wdata[PERIOD_W-1:0];
        REG_PERIOD_MAX: cfg_r.period_max       <= cfg_wdata[PERIOD_W-1:0];
        REG_DUTY_MIN:   cfg_r.duty_min         <= cfg_wdata[DUTY_W-1:0];
        REG_DUTY_MAX:   cfg_r.duty_max         <= cfg_wdata[DUTY_W-1:0];
        REG_MIN_PULSES: cfg_r.min_pulses       <= cfg_wdata[PULSES_W-1:0];
        REG_MAX_WTICKS: cfg_r.max_window_ticks <= cfg_wdata[WTICK_W-1:0];
        REG_OVF_LIMIT:  cfg_r.overflow_limit   <= cfg_wdata[OVF_W-1:0];
        default: ;
      endcase
    end
  end

  pfdm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pfdm_datapath #(
    .CAPTURE_WIDTH (CAPTURE_WIDTH),
    .SUM_WIDTH     (SUM_WIDTH),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_op             (in_op),
    .in_capture_value  (in_capture_value),
    .cmd               (cmd),
    .sts               (sts),
    .out_window_sum    (out_window_sum),
    .out_window_count  (out_window_count),
    .out_freq_q16      (out_freq_q16),
    .out_window_closed (out_window_closed)
  );

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_op == OP_TICK) |=> !in_ready)
    else $error("tick transaction did not hold off the input");

  a_event_single: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_op != OP_TICK) |=> in_ready)
    else $error("capture transaction stalled the input");

  a_zero_count_freq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_window_closed && out_window_count == '0) |-> (out_freq_q16 == '0))
    else $error("closed empty window reported nonzero frequency");

  a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_window_closed) |->
      (CPW'(out_window_count) < CPW'(cfg_r.min_pulses)))
    else $error("window left open with enough pulses");

endmodule
